### src/i2cm_pkg.sv
package i2cm_pkg;

    // Command codes carried on the input channel's tuser
    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_SEND  = 3'd3,
        KIND_RECV  = 3'd4,
        KIND_SACK  = 3'd5,
        KIND_RACK  = 3'd6,
        // unused code, behaves as no command
        KIND_RSVD  = 3'd7
    } kind_t;

    localparam int unsigned TICKS_W     = 16;
    localparam int unsigned PHASE_W     = 5;
    localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd720;

    // Input tdata layout (lowest bit first): tx_byte, ack_level, sda_in, pad
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 16;

    // Per-tick result of the sequencer
    typedef struct packed {
        logic       rx_ack;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl_out;
    } res_t;

    // Index of the final phase of each command
    function automatic logic [PHASE_W-1:0] last_phase(input kind_t cmd);
        logic [PHASE_W-1:0] lp;
        unique case (cmd)
            KIND_START: lp = 5'd3;
            KIND_STOP:  lp = 5'd2;
            KIND_SEND:  lp = 5'd23;
            KIND_RECV:  lp = 5'd24;
            KIND_SACK:  lp = 5'd2;
            KIND_RACK:  lp = 5'd3;
            default:    lp = 5'd0;
        endcase
        return lp;
    endfunction

endpackage

### src/i2c_master_bit_sequencer_top.sv
// I2C master bit sequencer driving open-drain SCL/SDA levels.
// Input channel (s_): one transfer per bit-timing tick. s_tuser carries the
// command kind (none, start, stop, send byte, receive byte, send ack,
// receive ack); s_tdata carries the byte to send, the ack level and the
// sampled SDA line level. A command given while one is in progress is dropped.
// Result channel (m_): exactly one transfer per input transfer, in order,
// with the SCL/SDA drive levels, busy, the done pulse, the last received
// byte and the last sampled ack bit.
// Config channel: cfg_data writes phase_ticks, the ticks each phase is held
// (0 acts as 1); write it only while no transfer is in flight from s_ to m_.
// A result reaches m_ through the input register, then the result register,
// which it enters on the sequencer step. Throughput: one transfer per
// cycle while m_tready stays high; the sequencer step lies between the two registers.
// Reset: both lines released high, no command, phase_ticks = 720.
// When m_tready is low the result register holds, the input register
// fills, and s_tready then drops until the result is taken.
module i2c_master_bit_sequencer_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: tx_byte[7:0], ack_level[8], sda_in[9], zero pad [15:10]
    input  logic [i2cm_pkg::IN_DATA_W-1:0]    s_tdata,
    // tuser: kind[2:0]
    input  logic [2:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: scl_out[0], sda_out[1], busy_res[2], done_res[3],
    //        rx_byte[11:4], rx_ack[12], zero pad [15:13]
    output logic [i2cm_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [i2cm_pkg::TICKS_W-1:0]      cfg_data
);
    import i2cm_pkg::*;

    logic               in_valid_reg;
    logic [2:0]         in_kind_reg;
    logic [7:0]         in_tx_reg;
    logic               in_ack_reg;
    logic               in_sda_reg;
    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [TICKS_W-1:0] ticks_reg;
    logic               out_free;
    logic               step;
    res_t               res;

    assign out_free  = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    i2cm_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .kind        (kind_t'(in_kind_reg)),
        .tx_byte     (in_tx_reg),
        .ack_level   (in_ack_reg),
        .sda_in      (in_sda_reg),
        .phase_ticks (ticks_reg),
        .res         (res)
    );

    // Hold the phase length register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= TICKS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            ticks_reg <= cfg_data;
        end
    end

    // Capture an input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= s_tuser;
            in_tx_reg   <= s_tdata[7:0];
            in_ack_reg  <= s_tdata[8];
            in_sda_reg  <= s_tdata[9];
        end
    end

    // Register the result and hold it until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= {3'd0, res.rx_ack, res.rx_byte, res.done_res,
                             res.busy_res, res.sda_out, res.scl_out};
        end
    end

endmodule

### src/i2cm_seq.sv
module i2cm_seq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step,
    input  i2cm_pkg::kind_t                kind,
    input  logic [7:0]                     tx_byte,
    input  logic                           ack_level,
    input  logic                           sda_in,
    input  logic [i2cm_pkg::TICKS_W-1:0]   phase_ticks,
    output i2cm_pkg::res_t                 res
);
    import i2cm_pkg::*;

    kind_t              cmd_reg,   cmd_next;
    logic [PHASE_W-1:0] idx_reg,   idx_next;
    logic [TICKS_W-1:0] wait_reg,  wait_next;
    logic [7:0]         shift_reg, shift_next;
    logic               scl_reg,   scl_next;
    logic               sda_reg,   sda_next;
    logic               ack_reg,   ack_next;
    logic [7:0]         rxh_reg,   rxh_next;
    // Position within a three-phase bit slot, and bit number for send byte
    logic [1:0]         slot_reg,  slot_next;
    logic [2:0]         bit_reg,   bit_next;

    logic [TICKS_W-1:0] hold;
    logic [TICKS_W-1:0] wait_dec;
    logic               run;
    logic               done;

    assign hold     = (phase_ticks == '0) ? TICKS_W'(1) : phase_ticks;
    assign wait_dec = wait_reg - TICKS_W'(1);

    always_comb begin
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        wait_next  = wait_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        rxh_next   = rxh_reg;
        slot_next  = slot_reg;
        bit_next   = bit_reg;
        run        = 1'b0;
        done       = 1'b0;

        // Start a command, or count down and step through its phases
        if (cmd_reg == KIND_NONE) begin
            if (kind != KIND_NONE && kind != KIND_RSVD) begin
                cmd_next  = kind;
                idx_next  = '0;
                slot_next = (kind == KIND_RECV) ? 2'd2 : 2'd0;
                bit_next  = 3'd7;
                if (kind == KIND_SEND) begin
                    shift_next = tx_byte;
                end else if (kind == KIND_SACK) begin
                    shift_next = {7'd0, ack_level};
                end else if (kind == KIND_RECV) begin
                    shift_next = 8'd0;
                end
                run       = 1'b1;
                wait_next = hold;
            end
        end else begin
            wait_next = wait_dec;
            if (wait_dec == '0) begin
                if (idx_reg >= last_phase(cmd_reg)) begin
                    done     = 1'b1;
                    if (cmd_reg == KIND_RECV) begin
                        rxh_next = shift_reg;
                    end
                    cmd_next = KIND_NONE;
                    idx_next = '0;
                end else begin
                    idx_next  = idx_reg + PHASE_W'(1);
                    slot_next = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
                    if (cmd_reg == KIND_SEND && slot_reg == 2'd2) begin
                        bit_next = bit_reg - 3'd1;
                    end
                    run       = 1'b1;
                    wait_next = hold;
                end
            end
        end

        // Apply the action of the phase just entered
        if (run) begin
            unique case (cmd_next)
                KIND_START: begin
                    unique case (idx_next)
                        5'd0:    sda_next = 1'b1;
                        5'd1:    scl_next = 1'b1;
                        5'd2:    sda_next = 1'b0;
                        default: scl_next = 1'b0;
                    endcase
                end
                KIND_STOP: begin
                    unique case (idx_next)
                        5'd0:    sda_next = 1'b0;
                        5'd1:    scl_next = 1'b1;
                        default: sda_next = 1'b1;
                    endcase
                end
                KIND_SEND: begin
                    unique case (slot_next)
                        2'd0:    sda_next = shift_next[bit_next];
                        2'd1:    scl_next = 1'b1;
                        default: scl_next = 1'b0;
                    endcase
                end
                KIND_RECV: begin
                    if (idx_next == '0) begin
                        sda_next = 1'b1;
                    end else begin
                        unique case (slot_next)
                            2'd0:    scl_next = 1'b1;
                            2'd1:    shift_next = {shift_next[6:0], sda_in};
                            default: scl_next = 1'b0;
                        endcase
                    end
                end
                KIND_SACK: begin
                    unique case (idx_next)
                        5'd0:    sda_next = shift_next[0];
                        5'd1:    scl_next = 1'b1;
                        default: scl_next = 1'b0;
                    endcase
                end
                KIND_RACK: begin
                    unique case (idx_next)
                        5'd0:    sda_next = 1'b1;
                        5'd1:    scl_next = 1'b1;
                        5'd2:    ack_next = sda_in;
                        default: scl_next = 1'b0;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Result of this tick, taken by the output register
    always_comb begin
        res.scl_out  = scl_next;
        res.sda_out  = sda_next;
        res.busy_res = (cmd_next != KIND_NONE);
        res.done_res = done;
        res.rx_byte  = rxh_next;
        res.rx_ack   = ack_next;
    end

    // Hold sequencer state; advance once per consumed tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_reg   <= KIND_NONE;
            idx_reg   <= '0;
            wait_reg  <= '0;
            shift_reg <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
            rxh_reg   <= '0;
            slot_reg  <= '0;
            bit_reg   <= '0;
        end else if (step) begin
            cmd_reg   <= cmd_next;
            idx_reg   <= idx_next;
            wait_reg  <= wait_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            rxh_reg   <= rxh_next;
            slot_reg  <= slot_next;
            bit_reg   <= bit_next;
        end
    end

endmodule

### sim/i2c_master_bit_sequencer_top_tb.sv
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_top_tb;
    import i2cm_pkg::*;

    localparam int STALL_LIMIT    = 4000;
    localparam int RANDOM_TICKS   = 700;
    localparam int MAX_MISMATCHES = 40;

    // Sda source selection for a command's ticks
    localparam int SDA_RANDOM = 0;
    localparam int SDA_LOW    = 1;
    localparam int SDA_HIGH   = 2;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // tdata: tx_byte[7:0], ack_level[8], sda_in[9], zero pad [15:10]
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    // tuser: kind[2:0]
    logic [2:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // tdata: scl_out[0], sda_out[1], busy_res[2], done_res[3],
    //        rx_byte[11:4], rx_ack[12], zero pad [15:13]
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [TICKS_W-1:0]    cfg_data  = '0;

    // Bus sequencer mirror
    kind_t              cur_cmd    = KIND_NONE;
    logic [PHASE_W-1:0] phase_idx  = '0;
    logic [TICKS_W-1:0] hold_left  = '0;
    logic [7:0]         shift_reg  = '0;
    logic               scl_lvl    = 1'b1;
    logic               sda_lvl    = 1'b1;
    logic               ack_bit    = 1'b0;
    logic [7:0]         rx_shown   = '0;
    logic [TICKS_W-1:0] ticks_cfg  = TICKS_RESET;

    res_t expected_levels[$];

    int error_count    = 0;
    int ticks_sent     = 0;
    int cmd_count      = 0;
    int done_count     = 0;
    int cfg_writes     = 0;
    int burst_left     = 0;
    int stalled_cycles = 0;

    i2c_master_bit_sequencer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Index of the closing phase of each command
    function automatic int end_phase(input kind_t cmd);
        case (cmd)
            KIND_START: return 3;
            KIND_STOP:  return 2;
            KIND_SEND:  return 23;
            KIND_RECV:  return 24;
            KIND_SACK:  return 2;
            KIND_RACK:  return 3;
            default:    return 0;
        endcase
    endfunction

    // Act out the current phase on the line levels
    task automatic apply_phase(input logic sda_bit);
        int p;
        p = phase_idx;
        case (cur_cmd)
            KIND_START: begin
                if (p == 0) sda_lvl = 1'b1;
                else if (p == 1) scl_lvl = 1'b1;
                else if (p == 2) sda_lvl = 1'b0;
                else scl_lvl = 1'b0;
            end
            KIND_STOP: begin
                if (p == 0) sda_lvl = 1'b0;
                else if (p == 1) scl_lvl = 1'b1;
                else sda_lvl = 1'b1;
            end
            KIND_SEND: begin
                if (p % 3 == 0) sda_lvl = shift_reg[7 - p / 3];
                else if (p % 3 == 1) scl_lvl = 1'b1;
                else scl_lvl = 1'b0;
            end
            KIND_RECV: begin
                if (p == 0) sda_lvl = 1'b1;
                else if ((p - 1) % 3 == 0) scl_lvl = 1'b1;
                else if ((p - 1) % 3 == 1) shift_reg = {shift_reg[6:0], sda_bit};
                else scl_lvl = 1'b0;
            end
            KIND_SACK: begin
                if (p == 0) sda_lvl = shift_reg[0];
                else if (p == 1) scl_lvl = 1'b1;
                else scl_lvl = 1'b0;
            end
            KIND_RACK: begin
                if (p == 0) sda_lvl = 1'b1;
                else if (p == 1) scl_lvl = 1'b1;
                else if (p == 2) ack_bit = sda_bit;
                else scl_lvl = 1'b0;
            end
            default: ;
        endcase
    endtask

    // Advance the mirror by one tick and queue the levels it produces
    task automatic step_sequencer(input logic [2:0] kind, input logic [7:0] txb,
                                  input logic ack_lvl, input logic sda_bit);
        logic [TICKS_W-1:0] hold;
        logic               done;
        res_t               r;
        hold = (ticks_cfg == 0) ? 16'd1 : ticks_cfg;
        done = 1'b0;
        if (cur_cmd == KIND_NONE) begin
            if (kind >= KIND_START && kind <= KIND_RACK) begin
                cur_cmd   = kind_t'(kind);
                phase_idx = '0;
                if (cur_cmd == KIND_SEND) shift_reg = txb;
                else if (cur_cmd == KIND_SACK) shift_reg = {7'd0, ack_lvl};
                else if (cur_cmd == KIND_RECV) shift_reg = '0;
                apply_phase(sda_bit);
                hold_left = hold;
                cmd_count++;
            end
        end else begin
            hold_left = hold_left - 1'b1;
            if (hold_left == 0) begin
                if (phase_idx >= end_phase(cur_cmd)) begin
                    done = 1'b1;
                    if (cur_cmd == KIND_RECV) rx_shown = shift_reg;
                    cur_cmd   = KIND_NONE;
                    phase_idx = '0;
                    done_count++;
                end else begin
                    phase_idx = phase_idx + 1'b1;
                    apply_phase(sda_bit);
                    hold_left = hold;
                end
            end
        end
        r.scl_out  = scl_lvl;
        r.sda_out  = sda_lvl;
        r.busy_res = (cur_cmd != KIND_NONE);
        r.done_res = done;
        r.rx_byte  = rx_shown;
        r.rx_ack   = ack_bit;
        expected_levels.push_back(r);
    endtask

    // Send one tick, with bursts and random gaps in front of it
    task automatic send_tick(input logic [2:0] kind, input logic [7:0] txb,
                             input logic ack_lvl, input logic sda_bit);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'd0, sda_bit, ack_lvl, txb};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        ticks_sent++;
        step_sequencer(kind, txb, ack_lvl, sda_bit);
    endtask

    function automatic logic pick_sda(input int mode);
        if (mode == SDA_LOW) return 1'b0;
        if (mode == SDA_HIGH) return 1'b1;
        return logic'($urandom_range(0, 1));
    endfunction

    // Send one tick with a random kind, dropped while a command is busy
    task automatic send_noise_tick();
        send_tick(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  logic'($urandom_range(0, 1)), pick_sda(SDA_RANDOM));
    endtask

    // Issue a command from idle and tick until it is done; intruders are
    // random kinds that land while busy and must be dropped
    task automatic run_command(input logic [2:0] kind, input logic [7:0] txb,
                               input logic ack_lvl, input int sda_mode,
                               input bit intrude);
        logic [2:0] fill_kind;
        send_tick(kind, txb, ack_lvl, pick_sda(sda_mode));
        while (cur_cmd != KIND_NONE) begin
            fill_kind = intrude ? 3'($urandom_range(0, 7)) : 3'(KIND_NONE);
            send_tick(fill_kind, 8'($urandom_range(0, 255)),
                      logic'($urandom_range(0, 1)), pick_sda(sda_mode));
        end
    endtask

    // Drop valid and hold until every queued result has come back
    task automatic settle_results();
        s_tvalid <= 1'b0;
        while (expected_levels.size() != 0) @(posedge aclk);
    endtask

    // Write phase_ticks once the pipeline is empty; a command may be running,
    // the new value then applies from its next phase
    task automatic set_phase_ticks(input logic [TICKS_W-1:0] value);
        settle_results();
        repeat (3) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        ticks_cfg = value;
        cfg_writes++;
    endtask

    // Reset value of phase_ticks: phase 0 of a start holds exactly 720 ticks,
    // then shorten the rest of the command
    task automatic test_default_ticks();
        send_tick(KIND_START, 8'h00, 1'b0, pick_sda(SDA_RANDOM));
        repeat (int'(TICKS_RESET) - 1) send_noise_tick();
        set_phase_ticks(16'd1);
        while (cur_cmd != KIND_NONE) send_noise_tick();
        run_command(KIND_STOP, 8'hFF, 1'b1, SDA_RANDOM, 1'b1);
    endtask

    // Every command at the shortest phase with extremes of the data, then start, rack and stop at two ticks
    task automatic test_each_command();
        set_phase_ticks(16'd1);
        run_command(KIND_START, 8'h5A, 1'b1, SDA_RANDOM, 1'b1);
        run_command(KIND_SEND, 8'h00, 1'b1, SDA_HIGH, 1'b0);
        run_command(KIND_SEND, 8'hFF, 1'b0, SDA_LOW, 1'b0);
        run_command(KIND_SEND, 8'hA5, 1'b0, SDA_RANDOM, 1'b1);
        run_command(KIND_RACK, 8'h00, 1'b0, SDA_LOW, 1'b0);
        run_command(KIND_RACK, 8'hFF, 1'b1, SDA_HIGH, 1'b1);
        run_command(KIND_RECV, 8'hFF, 1'b1, SDA_LOW, 1'b0);
        run_command(KIND_RECV, 8'h00, 1'b0, SDA_HIGH, 1'b0);
        run_command(KIND_RECV, 8'h3C, 1'b1, SDA_RANDOM, 1'b1);
        run_command(KIND_SACK, 8'hFF, 1'b0, SDA_HIGH, 1'b0);
        run_command(KIND_SACK, 8'h00, 1'b1, SDA_LOW, 1'b1);
        // the unused code behaves as no command
        run_command(KIND_RSVD, 8'hFF, 1'b1, SDA_RANDOM, 1'b0);
        run_command(KIND_NONE, 8'h81, 1'b1, SDA_RANDOM, 1'b0);
        run_command(KIND_STOP, 8'h7E, 1'b0, SDA_RANDOM, 1'b1);
        set_phase_ticks(16'd2);
        run_command(KIND_START, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
        run_command(KIND_RACK, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
        run_command(KIND_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
    endtask

    // A zero register value acts as one tick per phase
    task automatic test_zero_ticks();
        set_phase_ticks(16'd0);
        run_command(KIND_START, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
        run_command(KIND_SEND, 8'($urandom_range(0, 255)), 1'b0, SDA_RANDOM, 1'b1);
        run_command(KIND_RECV, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
        run_command(KIND_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
    endtask

    // Bus sessions with random content, plus noise and broken sequences
    task automatic test_random_sessions();
        int         first_tick;
        int         session;
        int         nbytes;
        bit         intrude;
        bit         reading;
        logic [7:0] addr;
        first_tick = ticks_sent;
        session    = 0;
        while (ticks_sent - first_tick < RANDOM_TICKS) begin
            if (session == 3) settle_results();
            if (session % 2 == 1)
                set_phase_ticks(($urandom_range(0, 5) == 0) ? 16'd0
                                                            : 16'($urandom_range(1, 6)));
            intrude = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 7) begin
                addr    = 8'($urandom_range(0, 255));
                reading = addr[0];
                nbytes  = $urandom_range(1, 3);
                run_command(KIND_START, 8'($urandom_range(0, 255)), 1'b0,
                            SDA_RANDOM, intrude);
                run_command(KIND_SEND, addr, logic'($urandom_range(0, 1)),
                            SDA_RANDOM, intrude);
                run_command(KIND_RACK, 8'($urandom_range(0, 255)), 1'b0,
                            SDA_RANDOM, intrude);
                for (int b = 0; b < nbytes; b++) begin
                    if (reading) begin
                        run_command(KIND_RECV, 8'($urandom_range(0, 255)), 1'b0,
                                    SDA_RANDOM, intrude);
                        run_command(KIND_SACK, 8'($urandom_range(0, 255)),
                                    logic'(b == nbytes - 1), SDA_RANDOM, intrude);
                    end else begin
                        run_command(KIND_SEND, 8'($urandom_range(0, 255)), 1'b0,
                                    SDA_RANDOM, intrude);
                        run_command(KIND_RACK, 8'($urandom_range(0, 255)), 1'b0,
                                    SDA_RANDOM, intrude);
                    end
                end
                // occasionally cut the session short without a stop
                if ($urandom_range(0, 7) != 0)
                    run_command(KIND_STOP, 8'($urandom_range(0, 255)), 1'b0,
                                SDA_RANDOM, intrude);
            end else begin
                repeat ($urandom_range(1, 6))
                    run_command(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                logic'($urandom_range(0, 1)), SDA_RANDOM, intrude);
            end
            session++;
        end
    endtask

    // Longest phase hold: start a command and check it holds its first phase;
    // it is left running at the end of the run
    task automatic test_max_ticks();
        set_phase_ticks(16'hFFFF);
        send_tick(KIND_SACK, 8'h00, 1'b1, pick_sda(SDA_RANDOM));
        repeat (120) send_noise_tick();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_default_ticks();
        test_each_command();
        test_zero_ticks();
        test_random_sessions();
        test_max_ticks();
        settle_results();
        repeat (4) @(posedge aclk);
        $display("Covered %0d ticks, %0d commands started, %0d completed,",
                 ticks_sent, cmd_count, done_count);
        $display("%0d phase_ticks writes incl. 0, 1 and 65535; %0d mismatches",
                 cfg_writes, error_count);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Receiver ready: spans of always-ready, random and periodic stalls
    initial begin
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 96);
            for (int i = 0; i < span; i++) begin
                @(posedge aclk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= logic'($urandom_range(0, 1));
                    default: m_tready <= ((i % 8) < 5);
                endcase
            end
        end
    end

    task automatic report_field(input string name, input logic [7:0] exp_v,
                                input logic [7:0] act_v);
        if (exp_v !== act_v) begin
            error_count++;
            if (error_count <= MAX_MISMATCHES)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
        end
    endtask

    // Compare each result transfer with the oldest expected levels
    always @(posedge aclk) begin
        res_t exp_r;
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[12:0];
            if (expected_levels.size() == 0) begin
                error_count++;
                if (error_count <= MAX_MISMATCHES)
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, m_tdata);
            end else begin
                exp_r = expected_levels.pop_front();
                report_field("scl_out", 8'(exp_r.scl_out), 8'(got.scl_out));
                report_field("sda_out", 8'(exp_r.sda_out), 8'(got.sda_out));
                report_field("busy_res", 8'(exp_r.busy_res), 8'(got.busy_res));
                report_field("done_res", 8'(exp_r.done_res), 8'(got.done_res));
                report_field("rx_byte", exp_r.rx_byte, got.rx_byte);
                report_field("rx_ack", 8'(exp_r.rx_ack), 8'(got.rx_ack));
                report_field("pad", 8'd0, 8'(m_tdata[15:13]));
            end
        end
    end

    // End the run when no transfer of any kind happens for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                stalled_cycles <= 0;
            else
                stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, %0d results still expected",
                         $time, expected_levels.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

endmodule
